// ===== sv/kway_coordinate_merge_top_assert.svh =====
// Assertion macros shared by the k-way coordinate merge modules.
`ifndef KWAY_COORDINATE_MERGE_TOP_ASSERT_SVH
`define KWAY_COORDINATE_MERGE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/kcm_pkg.sv =====
// Shared types, codes and constants for the k-way coordinate merge.
package kcm_pkg;

    // Default number of streams the storage is sized for.
    localparam int MAX_SOURCES_DEFAULT = 16;
    // Streams the 4-bit source field can address.
    localparam int SOURCE_FIELD_REACH  = 16;

    localparam int KEY_W      = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [4:0]       N_SOURCES_RESET = 5'd2;
    localparam logic [KEY_W-1:0] EMPTY_KEY       = '1;

    // Register index, taken from the word-address bit of paddr.
    localparam logic REG_N_SOURCES = 1'b0;

    // Input status codes.
    localparam logic [1:0] STATUS_RECORD  = 2'd0;
    localparam logic [1:0] STATUS_END     = 2'd1;
    localparam logic [1:0] STATUS_TRUNC   = 2'd2;
    localparam logic [1:0] STATUS_INVALID = 2'd3;

    // Result kind codes.
    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef struct packed {
        logic [3:0]         source;
        logic signed [31:0] ref_id;
        logic signed [31:0] position;
        logic               strand;
        logic [1:0]         status;
    } item_t;

    typedef struct packed {
        logic [3:0]       winner_source;
        logic [KEY_W-1:0] winner_key;
        logic [1:0]       kind;
        logic             truncated_warn;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
        logic scan;
        logic emit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad;
        logic fill_more;
        logic scan_done;
        logic out_busy;
    } dp_stat_t;

endpackage

// ===== sv/kcm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kcm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/kcm_ctrl.sv =====
// Controller state machine that sequences check, scan and result transfer.
`include "kway_coordinate_merge_top_assert.svh"
module kcm_ctrl
    import kcm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    // Next-state decode.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && ready_reg)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.bad)
                begin
                    state_next = S_EMIT;
                end
                else if (stat.fill_more)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd.capture = (state_reg == S_IDLE) && item_valid && ready_reg;
        cmd.commit  = (state_reg == S_CHECK);
        cmd.scan    = (state_reg == S_SCAN);
        cmd.emit    = (state_reg == S_EMIT) && !stat.out_busy;
    end

    assign item_ready = ready_reg;

    `KCM_ASSERT_IMPL(a_cmd_exclusive, clk, rst_n, 1'b1,
        $onehot0({cmd.capture, cmd.commit, cmd.scan, cmd.emit}), "commands overlap")

endmodule

// ===== sv/kcm_dp.sv =====
// Datapath: item register, head store, minimum scan and result register.
`include "kway_coordinate_merge_top_assert.svh"
module kcm_dp
    import kcm_pkg::*;
#(
    parameter int MAX_SOURCES = MAX_SOURCES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [4:0] n_sources,
    input  item_t      item,
    input  ctl_cmd_t   cmd,
    output dp_stat_t   stat,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result
);

    localparam int NS    = (MAX_SOURCES < SOURCE_FIELD_REACH) ? MAX_SOURCES
                                                              : SOURCE_FIELD_REACH;
    localparam int IDX_W = $clog2(NS);

    typedef enum logic {
        PHASE_FILLING,
        PHASE_MERGING
    } phase_t;

    // Item register (payload, no reset).
    item_t            item_reg;
    // Control state.
    phase_t           phase_reg;
    logic [4:0]       fill_count_reg;
    logic [3:0]       awaited_reg;
    logic [NS-1:0]    head_valid_reg;
    logic             reject_reg;
    logic             warn_reg;
    logic [4:0]       scan_cnt_reg;
    logic             cmp_vld_reg;
    logic             cmp_last_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             best_found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [KEY_W-1:0] best_key_reg;
    logic             out_valid_reg;
    result_t          result_reg;

    logic [4:0]       active;
    logic [5:0]       fill_inc;
    logic [31:0]      pos_inc;
    logic [KEY_W-1:0] item_key;
    logic [IDX_W-1:0] src_idx;
    logic             issue;
    logic             ram_we;
    logic [KEY_W-1:0] ram_rdata;
    logic             take_cand;

    // Streams in use, clamped to 1 .. NS.
    always_comb
    begin
        if (n_sources == 5'd0)
        begin
            active = 5'd1;
        end
        else if (32'(n_sources) > NS)
        begin
            active = 5'(NS);
        end
        else
        begin
            active = n_sources;
        end
    end

    // Key of the held item and its checks.
    assign pos_inc  = 32'(item_reg.position) + 32'd1;
    assign item_key = {32'(item_reg.ref_id), pos_inc[30:0], item_reg.strand};
    assign src_idx  = item_reg.source[IDX_W-1:0];
    assign fill_inc = {1'b0, fill_count_reg} + 6'd1;

    assign stat.bad = (item_reg.source != awaited_reg)
                   || (item_reg.status == STATUS_INVALID)
                   || (32'(item_reg.source) >= MAX_SOURCES);
    assign stat.fill_more = (phase_reg == PHASE_FILLING)
                         && (fill_inc < {1'b0, active});
    assign stat.scan_done = cmp_vld_reg && cmp_last_reg;
    assign stat.out_busy  = out_valid_reg && !result_ready;

    // Head key store.
    assign ram_we = cmd.commit && !stat.bad
                 && ((phase_reg == PHASE_FILLING) || (item_reg.status == STATUS_RECORD));
    assign issue  = cmd.scan && (scan_cnt_reg < active);

    kcm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (NS)
    ) u_head_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (src_idx),
        .wdata (item_key),
        .re    (issue),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // A read head takes the lead if it is valid and strictly smaller.
    assign take_cand = cmp_vld_reg && head_valid_reg[cmp_idx_reg]
                    && (!best_found_reg || (ram_rdata < best_key_reg));

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (take_cand)
        begin
            best_idx_reg <= cmp_idx_reg;
            best_key_reg <= ram_rdata;
        end
        if (cmd.emit)
        begin
            if (reject_reg)
            begin
                result_reg <= '{winner_source: awaited_reg, winner_key: '0,
                                kind: KIND_REJECT, truncated_warn: 1'b0};
            end
            else if (!best_found_reg)
            begin
                result_reg <= '{winner_source: 4'd0, winner_key: EMPTY_KEY,
                                kind: KIND_DONE, truncated_warn: warn_reg};
            end
            else
            begin
                result_reg <= '{winner_source: 4'(best_idx_reg), winner_key: best_key_reg,
                                kind: KIND_RECORD, truncated_warn: warn_reg};
            end
        end
    end

    // Control state: merge phase, stream heads, scan and output flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_FILLING;
            fill_count_reg <= '0;
            awaited_reg    <= '0;
            head_valid_reg <= '0;
            reject_reg     <= 1'b0;
            warn_reg       <= 1'b0;
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_last_reg   <= 1'b0;
            cmp_idx_reg    <= '0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Apply the held item; a truncation notice while merging raises the warning.
            if (cmd.commit)
            begin
                reject_reg     <= stat.bad;
                warn_reg       <= !stat.bad && (phase_reg == PHASE_MERGING)
                                  && (item_reg.status == STATUS_TRUNC);
                scan_cnt_reg   <= '0;
                best_found_reg <= 1'b0;
                if (!stat.bad)
                begin
                    if (phase_reg == PHASE_FILLING)
                    begin
                        head_valid_reg[src_idx] <= (item_reg.status == STATUS_RECORD);
                        fill_count_reg          <= fill_inc[4:0];
                        awaited_reg             <= fill_inc[3:0];
                    end
                    else if (item_reg.status == STATUS_RECORD)
                    begin
                        head_valid_reg[src_idx] <= 1'b1;
                    end
                    else if (item_reg.status == STATUS_END)
                    begin
                        head_valid_reg[src_idx] <= 1'b0;
                    end
                end
            end

            // Scan: one head read issued per cycle, compared once its registered read data returns.
            if (issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 5'd1;
            end
            cmp_vld_reg  <= issue;
            cmp_idx_reg  <= scan_cnt_reg[IDX_W-1:0];
            cmp_last_reg <= (scan_cnt_reg == active - 5'd1);
            if (take_cand)
            begin
                best_found_reg <= 1'b1;
            end

            // Result transfer and the state change it carries.
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (!reject_reg)
                begin
                    if (best_found_reg)
                    begin
                        phase_reg   <= PHASE_MERGING;
                        awaited_reg <= 4'(best_idx_reg);
                    end
                    else
                    begin
                        phase_reg      <= PHASE_FILLING;
                        fill_count_reg <= '0;
                        awaited_reg    <= '0;
                    end
                end
            end
            else if (out_valid_reg && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    `KCM_ASSERT_NEXT(a_done_rearms, clk, rst_n,
        cmd.emit && !reject_reg && !best_found_reg,
        phase_reg == PHASE_FILLING && fill_count_reg == 5'd0 && awaited_reg == 4'd0,
        "exhausted merge did not return to filling")
    `KCM_ASSERT_IMPL(a_winner_valid, clk, rst_n,
        cmd.emit && !reject_reg && best_found_reg,
        head_valid_reg[best_idx_reg], "chosen stream holds no head")
    `KCM_ASSERT_NEXT(a_reject_no_change, clk, rst_n, cmd.commit && stat.bad,
        $stable(head_valid_reg) && $stable(fill_count_reg) && $stable(phase_reg),
        "rejected item changed merge state")

endmodule

// ===== sv/kway_coordinate_merge_top.sv =====
// Top level of the k-way coordinate merge: config register, controller and datapath.
// Each accepted item is captured and checked; once all heads are filled, a scan of
// the head key RAM finds the smallest key and the result is registered for output.
// A new item is accepted only once the previous one is finished; the scan reads one
// head key per cycle. Filling items other than the last skip the scan and give no result; rejects skip the scan.
// Reset: rst_n clears all control state, n_sources returns to 2; head keys stay
// unset and are tracked by per-stream valid bits.
module kway_coordinate_merge_top
    import kcm_pkg::*;
#(
    parameter int MAX_SOURCES = MAX_SOURCES_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [4:0] n_sources_reg;
    logic       reg_sel;
    ctl_cmd_t   cmd;
    dp_stat_t   stat;

    // Register file: a single word-aligned register.
    assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_N_SOURCES);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_sources_reg <= N_SOURCES_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            n_sources_reg <= pwdata[4:0];
        end
    end

    assign prdata = reg_sel ? {{(CFG_DATA_W-5){1'b0}}, n_sources_reg} : '0;

    kcm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    kcm_dp #(
        .MAX_SOURCES (MAX_SOURCES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .n_sources    (n_sources_reg),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
